### rtl/nfpa_pkg.sv
// Package: geometry constants, codes, request/response and control types for the flash array.
package nfpa_pkg;

  localparam int MAX_BANKS   = 4;
  localparam int MAX_BLOCKS  = 64;
  localparam int MAX_PAGES   = 16;
  localparam int WORD_PAIRS  = 4;

  localparam int BLOCK_SLOTS = MAX_BANKS * MAX_BLOCKS;
  localparam int PAGE_SLOTS  = BLOCK_SLOTS * MAX_PAGES;
  localparam int BSLOT_W     = $clog2(BLOCK_SLOTS);
  localparam int PSLOT_W     = $clog2(PAGE_SLOTS);
  localparam int CNT_W       = $clog2(MAX_PAGES + 1);
  localparam int PAGE_W      = WORD_PAIRS * 64 + 32;

  localparam int BANKS_W     = 3;
  localparam int BLOCKS_W    = 7;
  localparam int PAGES_W     = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_PROGRAM = 2'd1;
  localparam logic [1:0] OP_ERASE   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_BANK  = 3'd1;
  localparam logic [2:0] ST_BAD_BLOCK = 3'd2;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd3;
  localparam logic [2:0] ST_WRITTEN   = 3'd4;
  localparam logic [2:0] ST_NOT_SEQ   = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;
  localparam logic [2:0] ST_FREE      = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_BANK_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_BANK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 2'd2;

  localparam logic [BANKS_W-1:0]  BANK_RESET  = 3'd4;
  localparam logic [BLOCKS_W-1:0] BLOCK_RESET = 7'd64;
  localparam logic [PAGES_W-1:0]  PAGE_RESET  = 5'd16;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  bank_index;
    logic [5:0]  block_index;
    logic [3:0]  page_index;
    logic [63:0] data_words_01;
    logic [63:0] data_words_23;
    logic [63:0] data_words_45;
    logic [63:0] data_words_67;
    logic [31:0] spare_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_words_01;
    logic [63:0] read_words_23;
    logic [63:0] read_words_45;
    logic [63:0] read_words_67;
    logic [31:0] spare_out;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic [BSLOT_W-1:0] addr;
    logic [CNT_W-1:0]   data;
  } cnt_wr_t;

endpackage

### rtl/nfpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module nfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/nfpa_count_store.sv
// Per-block programmed page counts: RAM plus valid bits that read unwritten entries as zero.
module nfpa_count_store
  import nfpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [BSLOT_W-1:0] raddr,
  input  cnt_wr_t            wr,
  output logic [CNT_W-1:0]   count
);

  logic [BLOCK_SLOTS-1:0] valid;
  logic                   rd_valid;
  logic [CNT_W-1:0]       rd_data;

  nfpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BLOCK_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  assign count = rd_valid ? rd_data : '0;

endmodule

### rtl/nfpa_core.sv
// Command evaluation: range checks, count rules, page store access and result register.
module nfpa_core
  import nfpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [BANKS_W-1:0]    bank_count,
  input  logic [BLOCKS_W-1:0]   blocks_per_bank,
  input  logic [PAGES_W-1:0]    pages_per_block,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rsp_t                  out_data,
  output state_t                state_q,
  output logic                  done,
  output cnt_wr_t               cnt_wr,
  output logic                  page_we
);

  state_t              state, state_next;
  req_t                req;
  logic [BSLOT_W-1:0]  bslot_rd;
  logic [PSLOT_W-1:0]  pslot_rd;
  logic [BSLOT_W-1:0]  bslot;
  logic [PSLOT_W-1:0]  pslot;
  logic [CNT_W-1:0]    cnt;
  logic [PAGE_W-1:0]   page_rdata;
  logic [PAGE_W-1:0]   page_wdata;
  logic [BANKS_W-1:0]  nb;
  logic [BLOCKS_W-1:0] nk;
  logic [PAGES_W-1:0]  np;
  logic [CNT_W-1:0]    page_ext;
  logic [2:0]          status;
  logic                accept;
  rsp_t                rsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign state_q  = state;

  assign bslot_rd = (state == S_IDLE) ? {in_data.bank_index, in_data.block_index}
                                      : {req.bank_index, req.block_index};
  assign pslot_rd = (state == S_IDLE)
                  ? {in_data.bank_index, in_data.block_index, in_data.page_index}
                  : {req.bank_index, req.block_index, req.page_index};
  assign bslot    = {req.bank_index, req.block_index};
  assign pslot    = {req.bank_index, req.block_index, req.page_index};

  nfpa_count_store u_count (
    .clk   (clk),
    .rst   (rst),
    .raddr (bslot_rd),
    .wr    (cnt_wr),
    .count (cnt)
  );

  assign page_wdata = {req.spare_in, req.data_words_67, req.data_words_45,
                       req.data_words_23, req.data_words_01};

  nfpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (PAGE_SLOTS)
  ) u_pages (
    .clk   (clk),
    .we    (page_we),
    .waddr (pslot),
    .wdata (page_wdata),
    .raddr (pslot_rd),
    .rdata (page_rdata)
  );

  assign nb = (bank_count > BANKS_W'(MAX_BANKS)) ? BANKS_W'(MAX_BANKS) : bank_count;
  assign nk = (blocks_per_bank > BLOCKS_W'(MAX_BLOCKS)) ? BLOCKS_W'(MAX_BLOCKS)
                                                        : blocks_per_bank;
  assign np = (pages_per_block > PAGES_W'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES)
                                                      : pages_per_block;
  assign page_ext = CNT_W'(req.page_index);

  always_comb begin
    status = ST_OK;
    if (req.operation == OP_NONE) begin
      status = ST_OK;
    end else if (BANKS_W'(req.bank_index) >= nb) begin
      status = ST_BAD_BANK;
    end else if (BLOCKS_W'(req.block_index) >= nk) begin
      status = ST_BAD_BLOCK;
    end else if (req.operation != OP_ERASE && PAGES_W'(req.page_index) >= np) begin
      status = ST_BAD_PAGE;
    end else begin
      case (req.operation)
        OP_ERASE: begin
          if (cnt == '0 || np == '0) status = ST_FREE;
        end
        OP_PROGRAM: begin
          if (cnt > page_ext) status = ST_WRITTEN;
          else if (cnt < page_ext) status = ST_NOT_SEQ;
        end
        OP_READ: begin
          if (page_ext >= cnt) status = ST_EMPTY;
        end
        default: status = ST_OK;
      endcase
    end
  end

  always_comb begin
    state_next  = state;
    done        = 1'b0;
    cnt_wr.en   = 1'b0;
    cnt_wr.addr = bslot;
    cnt_wr.data = '0;
    page_we     = 1'b0;
    rsp         = '0;
    rsp.status  = status;
    if (status == ST_OK && req.operation == OP_READ) begin
      rsp.read_words_01 = page_rdata[63:0];
      rsp.read_words_23 = page_rdata[127:64];
      rsp.read_words_45 = page_rdata[191:128];
      rsp.read_words_67 = page_rdata[255:192];
      rsp.spare_out     = page_rdata[287:256];
    end
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (!out_valid || !out_stall) begin
          done       = 1'b1;
          state_next = S_IDLE;
          if (status == ST_OK && req.operation == OP_ERASE) begin
            cnt_wr.en = 1'b1;
          end
          if (status == ST_OK && req.operation == OP_PROGRAM) begin
            cnt_wr.en   = 1'b1;
            cnt_wr.data = cnt + CNT_W'(1);
            page_we     = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_data;
    end
    if (done) begin
      out_data <= rsp;
    end
  end

endmodule

### rtl/nand_flash_page_array_model_core.sv
// Top level: NAND flash page array model with configuration registers.
// Timing: an accepted request moves to the lookup state, which waits on the registered read
// of the count and page RAMs and registers the result once the result register is free.
// Flow: a new request is taken only in the idle state, not before the last one has left
// lookup; the lookup state holds while the result register is still stalled.
// Reset: synchronous; restores the default geometry and marks every block erased at once.
// Page contents are not cleared and are undefined until programmed.
module nand_flash_page_array_model_core
  import nfpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rsp_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [BANKS_W-1:0]  bank_count;
  logic [BLOCKS_W-1:0] blocks_per_bank;
  logic [PAGES_W-1:0]  pages_per_block;
  state_t              state;
  logic                done;
  cnt_wr_t             cnt_wr;
  logic                page_we;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_count      <= BANK_RESET;
      blocks_per_bank <= BLOCK_RESET;
      pages_per_block <= PAGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BANK_COUNT:      bank_count      <= cfg_data[BANKS_W-1:0];
        CFG_BLOCKS_PER_BANK: blocks_per_bank <= cfg_data[BLOCKS_W-1:0];
        CFG_PAGES_PER_BLOCK: pages_per_block <= cfg_data[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  nfpa_core u_core (
    .clk             (clk),
    .rst             (rst),
    .bank_count      (bank_count),
    .blocks_per_bank (blocks_per_bank),
    .pages_per_block (pages_per_block),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .state_q         (state),
    .done            (done),
    .cnt_wr          (cnt_wr),
    .page_we         (page_we)
  );

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_LOOKUP))
    else $error("accepted request did not enter lookup");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("completed request left no result");

  a_page_write_ok: assert property (@(posedge clk) disable iff (rst)
    page_we |-> (done && cnt_wr.en))
    else $error("page write outside a successful program");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_wr.en |-> (cnt_wr.data <= CNT_W'(MAX_PAGES)))
    else $error("page count beyond block size");

endmodule
